// File: rtl/dec7_pkg.sv
// shared types, constants and helper functions for the debounced event counter
// no dependencies; used by every other file of the block
`default_nettype none

package dec7_pkg;

  localparam int unsigned COUNT_W   = 14;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 14'd9999;

  localparam logic [HOLD_W-1:0] HOLDOFF_THRESHOLD_RST = 16'd1000;
  localparam logic [HOLD_W-1:0] HOLDOFF_LIMIT_RST     = 16'd2000;

  // reciprocal of ten, scaled by 2^19, exact for every 14-bit value
  localparam logic [15:0] RECIP10       = 16'd52429;
  localparam int unsigned RECIP10_SHIFT = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLDOFF_THRESHOLD = 1'b0,
    CFG_HOLDOFF_LIMIT     = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_TICK    = 1'b0,
    KIND_RESTORE = 1'b1
  } kind_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic [COUNT_W-1:0] count_prev;
    logic [COUNT_W-1:0] new_count;
    logic               store_write;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // floor(x / 10) by multiplication with the scaled reciprocal
  function automatic logic [COUNT_W-1:0] div10(input logic [COUNT_W-1:0] x);
    logic [COUNT_W+15:0] prod;
    prod = {16'd0, x} * {{COUNT_W{1'b0}}, RECIP10};
    return COUNT_W'(prod >> RECIP10_SHIFT);
  endfunction

  // x - 10*q, known to be below ten
  function automatic logic [DIGIT_W-1:0] rem10(input logic [COUNT_W-1:0] x,
                                               input logic [COUNT_W-1:0] q);
    logic [COUNT_W-1:0] diff;
    diff = x - ((q << 3) + (q << 1));
    return diff[DIGIT_W-1:0];
  endfunction

  // active-low segment code of one decimal digit
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] code;
    unique case (d)
      4'd0:    code = 8'b1000_0000;
      4'd1:    code = 8'b1001_1011;
      4'd2:    code = 8'b0100_1000;
      4'd3:    code = 8'b0000_1010;
      4'd4:    code = 8'b0001_0011;
      4'd5:    code = 8'b0010_0010;
      4'd6:    code = 8'b0010_0000;
      4'd7:    code = 8'b1000_1011;
      4'd8:    code = 8'b0000_0000;
      4'd9:    code = 8'b0000_0010;
      default: code = 8'b1111_1111;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dec7_in_if.sv
// input channel of the event counter: valid/ready plus tick or restore fields
// depends on dec7_pkg for field widths
`default_nettype none

interface dec7_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic                             line_level;
  logic                             button_level;
  logic [dec7_pkg::COUNT_W-1:0]     restore_value;

  modport source (output valid, output kind, output line_level,
                  output button_level, output restore_value, input ready);
  modport sink   (input valid, input kind, input line_level,
                  input button_level, input restore_value, output ready);
endinterface

`default_nettype wire

// File: rtl/dec7_out_if.sv
// result channel of the event counter: valid/ready plus segment codes and count
// depends on dec7_pkg for field widths
`default_nettype none

interface dec7_out_if;
  logic                             valid;
  logic                             ready;
  logic [dec7_pkg::SEG_W-1:0]       seg_ones;
  logic [dec7_pkg::SEG_W-1:0]       seg_tens;
  logic [dec7_pkg::SEG_W-1:0]       seg_hundreds;
  logic [dec7_pkg::SEG_W-1:0]       seg_thousands;
  logic [dec7_pkg::COUNT_W-1:0]     new_count;
  logic                             store_write;

  modport source (output valid, output seg_ones, output seg_tens, output seg_hundreds,
                  output seg_thousands, output new_count, output store_write,
                  input ready);
  modport sink   (input valid, input seg_ones, input seg_tens, input seg_hundreds,
                  input seg_thousands, input new_count, input store_write,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/dec7_front.sv
// front end: config registers, edge detect, hold-off counter and event count
// depends on dec7_pkg and dec7_in_if; pushes one entry per accepted item
`default_nettype none

module dec7_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dec7_in_if.sink                                in_ch,
  input  wire logic                              cfg_we,
  input  wire logic [dec7_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dec7_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire dec7_pkg::q_stat_t                 q_stat,
  output dec7_pkg::q_push_t                      q_push
);

  logic [dec7_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                         prev_r, prev_nxt;
  logic [dec7_pkg::HOLD_W-1:0]  hold_r, hold_nxt;
  logic [dec7_pkg::HOLD_W-1:0]  thr_r, thr_nxt;
  logic [dec7_pkg::HOLD_W-1:0]  lim_r, lim_nxt;

  logic                         accept;
  logic                         is_tick;
  logic                         counted;
  logic [dec7_pkg::COUNT_W-1:0] restore_clamped;
  logic [dec7_pkg::COUNT_W-1:0] count_inc;
  logic [dec7_pkg::HOLD_W-1:0]  hold_base;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_tick     = (dec7_pkg::kind_t'(in_ch.kind) == dec7_pkg::KIND_TICK);

  // falling edge with button held and hold-off expired
  assign counted = is_tick && prev_r && !in_ch.line_level && !in_ch.button_level
                   && (hold_r > thr_r);

  assign restore_clamped = (in_ch.restore_value > dec7_pkg::COUNT_MAX) ?
                           dec7_pkg::COUNT_MAX : in_ch.restore_value;
  assign count_inc = (count_r >= dec7_pkg::COUNT_MAX) ? '0 : count_r + 1'b1;
  assign hold_base = counted ? '0 : hold_r;

  always_comb begin
    count_nxt = count_r;
    prev_nxt  = prev_r;
    hold_nxt  = hold_r;
    if (accept) begin
      if (!is_tick) begin
        count_nxt = restore_clamped;
      end else begin
        if (counted) begin
          count_nxt = count_inc;
        end
        prev_nxt = in_ch.line_level;
        hold_nxt = (hold_base < lim_r) ? hold_base + 1'b1 : lim_r;
      end
    end
  end

  always_comb begin
    thr_nxt = thr_r;
    lim_nxt = lim_r;
    if (cfg_we) begin
      unique case (dec7_pkg::cfg_idx_t'(cfg_index))
        dec7_pkg::CFG_HOLDOFF_THRESHOLD: thr_nxt = cfg_data;
        dec7_pkg::CFG_HOLDOFF_LIMIT:     lim_nxt = cfg_data;
      endcase
    end
  end

  assign q_push.valid             = accept;
  assign q_push.entry.count_prev  = count_r;
  assign q_push.entry.new_count   = count_nxt;
  assign q_push.entry.store_write = accept && counted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      prev_r  <= 1'b0;
      hold_r  <= '0;
      thr_r   <= dec7_pkg::HOLDOFF_THRESHOLD_RST;
      lim_r   <= dec7_pkg::HOLDOFF_LIMIT_RST;
    end else begin
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
      hold_r  <= hold_nxt;
      thr_r   <= thr_nxt;
      lim_r   <= lim_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dec7_queue.sv
// two-entry queue between front and back
// depends on dec7_pkg for the entry and status structs
`default_nettype none

module dec7_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dec7_pkg::q_push_t    q_push,
  input  wire logic                 pop,
  output dec7_pkg::q_stat_t         q_stat,
  output dec7_pkg::entry_t          head
);

  dec7_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign head         = mem_r[rd_ptr_r];

  assign do_push = q_push.valid && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dec7_back.sv
// back end: decimal split of the shown count over three stages, segment encode
// depends on dec7_pkg, dec7_out_if; pops one entry per cycle unless stalled
`default_nettype none

module dec7_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dec7_pkg::q_stat_t    q_stat,
  input  wire dec7_pkg::entry_t     head,
  output logic                      pop,
  dec7_out_if.source                out_ch
);

  localparam int unsigned CW = dec7_pkg::COUNT_W;
  localparam int unsigned DW = dec7_pkg::DIGIT_W;
  localparam int unsigned SW = dec7_pkg::SEG_W;

  logic adv;

  // stage one: ones digit
  logic          s1_v_r, s1_v_nxt;
  logic [CW-1:0] s1_q_r;
  logic [DW-1:0] s1_d0_r;
  logic [CW-1:0] s1_cnt_r;
  logic          s1_st_r;

  // stage two: tens digit
  logic          s2_v_r, s2_v_nxt;
  logic [CW-1:0] s2_q_r;
  logic [DW-1:0] s2_d0_r, s2_d1_r;
  logic [CW-1:0] s2_cnt_r;
  logic          s2_st_r;

  // output register
  logic          o_v_r, o_v_nxt;
  logic [SW-1:0] o_ones_r, o_tens_r, o_hund_r, o_thou_r;
  logic [CW-1:0] o_cnt_r;
  logic          o_st_r;

  logic [CW-1:0] q1, q2, q3;
  logic [DW-1:0] d0, d1, d2;

  assign adv = !o_v_r || out_ch.ready;
  assign pop = adv && !q_stat.empty;

  assign q1 = dec7_pkg::div10(head.count_prev);
  assign d0 = dec7_pkg::rem10(head.count_prev, q1);
  assign q2 = dec7_pkg::div10(s1_q_r);
  assign d1 = dec7_pkg::rem10(s1_q_r, q2);
  assign q3 = dec7_pkg::div10(s2_q_r);
  assign d2 = dec7_pkg::rem10(s2_q_r, q3);

  always_comb begin
    s1_v_nxt = s1_v_r;
    s2_v_nxt = s2_v_r;
    o_v_nxt  = o_v_r;
    if (adv) begin
      s1_v_nxt = pop;
      s2_v_nxt = s1_v_r;
      o_v_nxt  = s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_q_r   <= q1;
      s1_d0_r  <= d0;
      s1_cnt_r <= head.new_count;
      s1_st_r  <= head.store_write;

      s2_q_r   <= q2;
      s2_d0_r  <= s1_d0_r;
      s2_d1_r  <= d1;
      s2_cnt_r <= s1_cnt_r;
      s2_st_r  <= s1_st_r;

      o_ones_r <= dec7_pkg::seg_code(s2_d0_r);
      o_tens_r <= dec7_pkg::seg_code(s2_d1_r);
      o_hund_r <= dec7_pkg::seg_code(d2);
      o_thou_r <= dec7_pkg::seg_code(q3[DW-1:0]);
      o_cnt_r  <= s2_cnt_r;
      o_st_r   <= s2_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  assign out_ch.valid         = o_v_r;
  assign out_ch.seg_ones      = o_ones_r;
  assign out_ch.seg_tens      = o_tens_r;
  assign out_ch.seg_hundreds  = o_hund_r;
  assign out_ch.seg_thousands = o_thou_r;
  assign out_ch.new_count     = o_cnt_r;
  assign out_ch.store_write   = o_st_r;

endmodule

`default_nettype wire

// File: rtl/debounced_event_counter_7seg.sv
// top level of the debounced event counter with seven-segment readout
// depends on dec7_pkg, dec7_in_if, dec7_out_if, dec7_front, dec7_queue, dec7_back
//
// channel   dir   handshake          payload
// in_ch     in    valid/ready        kind, line_level, button_level, restore_value
// out_ch    out   valid/ready        seg_ones..seg_thousands, new_count, store_write
// cfg_*     in    cfg_we only        cfg_index selects register, cfg_data 16 bits
//
// one item accepted per cycle while the queue is not full; the state update
// happens in the accept cycle; a result reaches out_ch via the queue slot, the
// two decimal-split stages and the output register, and a stalled out_ch holds them
// rst_n is synchronous and active low; config returns to 1000 / 2000
// in_ch.ready drops only when the two-entry queue is full, so a stalled
// out_ch back-pressures the input after the pipeline and queue fill up
`default_nettype none

module debounced_event_counter_7seg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dec7_in_if.sink                                in_ch,
  dec7_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [dec7_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dec7_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // front to queue
  dec7_pkg::q_push_t q_push;
  // queue fill status, seen by both sides
  dec7_pkg::q_stat_t q_stat;
  // head entry of the queue and its pop strobe from the back
  dec7_pkg::entry_t  head;
  logic              pop;

  // front: classifies each item, owns count, edge and hold-off state
  dec7_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push)
  );

  // decouples the front from output stalls
  dec7_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  // back: splits the shown count into digits and encodes segments
  dec7_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // the count handed out never leaves the four-digit range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.new_count <= dec7_pkg::COUNT_MAX))
    else $error("new_count above 9999");

  // the front never offers an item to a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> !q_stat.full)
    else $error("push into full queue");

  // the back never drains an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_stat.empty) == 1'b0)
    else $error("pop from empty queue");

  // a counted edge only happens on a tick
  a_store_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.entry.store_write |-> (q_push.valid && !in_ch.kind))
    else $error("store flagged without a tick");

endmodule

`default_nettype wire
